// ===== rtl/gpdd_pkg.sv =====
// ----------------------------------------------------------------------------
// gpdd_pkg
// Shared types and constants for the GF(2) P*L*U product dedup block.
// ----------------------------------------------------------------------------
package gpdd_pkg;

	localparam int MAT_DIM_DEF = 4;

	localparam int PROD_W      = 16;
	localparam int COUNT_W     = 17;
	localparam int SEEN_ROW_W  = 32;
	localparam int SEEN_SEL_W  = $clog2(SEEN_ROW_W);
	localparam int SEEN_ROWS   = (1 << PROD_W) / SEEN_ROW_W;
	localparam int SEEN_ADDR_W = $clog2(SEEN_ROWS);
	localparam int COUNT_MAX   = 1 << PROD_W;

	typedef struct packed {
		logic [7:0] row_map;
		logic [5:0] lower_bits;
		logic [5:0] upper_bits;
	} in_word_t;

	typedef struct packed {
		logic [PROD_W-1:0]  product_bits;
		logic               is_new;
		logic [COUNT_W-1:0] distinct_count;
	} out_word_t;

	typedef struct packed {
		logic clear_en;
		logic load;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic clear_last;
	} dp_status_t;

endpackage

// ===== rtl/gpdd_datapath.sv =====
// ----------------------------------------------------------------------------
// gpdd_datapath
// Product logic, seen bitmap memory, distinct counter and result register.
// ----------------------------------------------------------------------------
module gpdd_datapath import gpdd_pkg::*; #(
	parameter int MAT_DIM = MAT_DIM_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  in_word_t   item,
	input  dp_cmd_t    cmd,
	output dp_status_t status,
	output out_word_t  result
);

	logic [MAT_DIM-1:0] lrow [MAT_DIM];
	logic [MAT_DIM-1:0] urow [MAT_DIM];
	logic [MAT_DIM-1:0] arow [MAT_DIM];
	logic [PROD_W-1:0]  product;

	logic [PROD_W-1:0]      prod_q;
	logic [SEEN_ROW_W-1:0]  rdata_q;
	logic [COUNT_W-1:0]     count_q;
	logic [SEEN_ADDR_W-1:0] clr_row_q;
	out_word_t              result_q;

	logic [SEEN_ROW_W-1:0] seen_mem [SEEN_ROWS];

	logic                   fresh;
	logic                   mem_we;
	logic [SEEN_ADDR_W-1:0] mem_waddr;
	logic [SEEN_ROW_W-1:0]  mem_wdata;
	logic [COUNT_W-1:0]     count_next;

	for (genvar gi = 0; gi < MAT_DIM; gi++) begin : g_row
		for (genvar gj = 0; gj < MAT_DIM; gj++) begin : g_col
			if (gj == gi) begin : g_diag
				assign lrow[gi][gj] = 1'b1;
				assign urow[gi][gj] = 1'b1;
			end else if (gj < gi) begin : g_low
				localparam int LPos = gi * (gi - 1) / 2 + gj;
				assign lrow[gi][gj] = item.lower_bits[LPos];
				assign urow[gi][gj] = 1'b0;
			end else begin : g_up
				localparam int UPos = gi * (MAT_DIM - 1) - gi * (gi - 1) / 2 + gj - gi - 1;
				assign lrow[gi][gj] = 1'b0;
				assign urow[gi][gj] = item.upper_bits[UPos];
			end
		end
	end

	for (genvar gi = 0; gi < MAT_DIM; gi++) begin : g_prod
		logic [1:0]         col;
		logic [MAT_DIM-1:0] pl;
		logic [MAT_DIM-1:0] acc;

		assign col = item.row_map[2*gi +: 2];

		always_comb begin
			pl = '0;
			for (int c = 0; c < MAT_DIM; c++) begin
				if (col == 2'(c)) begin
					pl = lrow[c];
				end
			end
		end

		always_comb begin
			acc = '0;
			for (int k = 0; k < MAT_DIM; k++) begin
				if (pl[k]) begin
					acc = acc ^ urow[k];
				end
			end
		end

		assign arow[gi] = acc;
	end

	always_comb begin
		product = '0;
		for (int i = 0; i < MAT_DIM; i++) begin
			product[i*MAT_DIM +: MAT_DIM] = arow[i];
		end
	end

	assign fresh      = ~rdata_q[prod_q[SEEN_SEL_W-1:0]];
	assign count_next = count_q + COUNT_W'(1);

	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_row_q;
		mem_wdata = '0;
		if (cmd.clear_en) begin
			mem_we = 1'b1;
		end else if (cmd.update && fresh) begin
			mem_we    = 1'b1;
			mem_waddr = prod_q[PROD_W-1:SEEN_SEL_W];
			mem_wdata = rdata_q | (SEEN_ROW_W'(1) << prod_q[SEEN_SEL_W-1:0]);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			seen_mem[mem_waddr] <= mem_wdata;
		end
		rdata_q <= seen_mem[prod_q[PROD_W-1:SEEN_SEL_W]];
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			prod_q <= product;
		end
		if (cmd.update) begin
			result_q.product_bits   <= prod_q;
			result_q.is_new         <= fresh;
			result_q.distinct_count <= fresh ? count_next : count_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			clr_row_q <= '0;
		end else begin
			if (cmd.clear_en) begin
				clr_row_q <= clr_row_q + SEEN_ADDR_W'(1);
			end
			if (cmd.update && fresh) begin
				count_q <= count_next;
			end
		end
	end

	assign status.clear_last = (clr_row_q == SEEN_ADDR_W'(SEEN_ROWS - 1));
	assign result            = result_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(COUNT_MAX))
		else $error("distinct count beyond bitmap size");
`endif

endmodule

// ===== rtl/gpdd_ctrl.sv =====
// ----------------------------------------------------------------------------
// gpdd_ctrl
// Sequencer: bitmap clearing pass, then load, lookup and update per word.
// ----------------------------------------------------------------------------
module gpdd_ctrl import gpdd_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  dp_status_t status,
	output dp_cmd_t    cmd,
	output logic       busy,
	output logic       done
);

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_LOOKUP,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   done_q;

	assign cmd.clear_en = (state_q == ST_CLEAR);
	assign cmd.load     = (state_q == ST_IDLE) && start;
	assign cmd.update   = (state_q == ST_UPDATE);
	assign busy         = (state_q != ST_IDLE);
	assign done         = done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_UPDATE);
			case (state_q)
				ST_CLEAR: begin
					if (status.clear_last) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_LOOKUP;
					end
				end
				ST_LOOKUP: begin
					state_q <= ST_UPDATE;
				end
				ST_UPDATE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	a_done_after_update: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(state_q == ST_UPDATE))
		else $error("done without an update cycle");
	a_load_to_lookup: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ST_LOOKUP)
		else $error("load did not advance to lookup");
	a_cmd_exclusive: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.clear_en, cmd.load, cmd.update}))
		else $error("overlapping datapath commands");
	a_clear_exit: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.clear_en && status.clear_last) |=> state_q == ST_IDLE)
		else $error("clearing pass did not end");
`endif

endmodule

// ===== rtl/gf2_plu_product_dedup.sv =====
// ----------------------------------------------------------------------------
// gf2_plu_product_dedup
// Forms P*L*U over GF(2) and flags repeated products through a seen bitmap.
// Steps: the word is loaded on the accepting edge, its bitmap row is read in
// LOOKUP, then UPDATE sets result and done; busy stays high until idle again.
// Reset: a clearing pass over the whole bitmap (one 32-bit row a cycle)
// runs with busy high; the distinct count starts at zero.
// Results show on result for one cycle with done; the receiver cannot stall.
// ----------------------------------------------------------------------------
module gf2_plu_product_dedup import gpdd_pkg::*; #(
	parameter int MAT_DIM = MAT_DIM_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	input  in_word_t  item,
	output logic      done,
	output out_word_t result
);

	dp_cmd_t    cmd;
	dp_status_t status;

	gpdd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	gpdd_datapath #(
		.MAT_DIM (MAT_DIM)
	) u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.status (status),
		.result (result)
	);

endmodule
